/* hw/rtl/bounded_set_min_max_span_macros.svh */
// assertion macros for the bounded set min/max span block
// no dependencies; included by the top level
`ifndef BOUNDED_SET_MIN_MAX_SPAN_MACROS_SVH
`define BOUNDED_SET_MIN_MAX_SPAN_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BSMMS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsmms assertion failed");
`define BSMMS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsmms assertion failed");
`else
`define BSMMS_ASSERT_IMP(label, clk, rst, ante, cons)
`define BSMMS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/bsmms_pkg.sv */
// shared types and constants for the bounded set min/max span block
// no dependencies
`timescale 1ns / 1ps
package bsmms_pkg;

  localparam int MAX_VALUES_DEF = 64;
  localparam int VAL_W          = 32;
  localparam int CNT_W          = 7;
  localparam int IN_W           = 64;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;
  localparam int OUT_DATA_W     = 72;
  localparam int OUT_USER_W     = 3;

  localparam logic [VAL_W-1:0]   GAP_INIT = '1;
  localparam logic [PADDR_W-1:0] CAPACITY_ADDR = 3'd0;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

endpackage

/* hw/rtl/bsmms_mem.sv */
// value store: one write port, one registered read port
// depends on bsmms_pkg
`timescale 1ns / 1ps
module bsmms_mem #(
  parameter int DEPTH = bsmms_pkg::MAX_VALUES_DEF
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(DEPTH)-1:0]          waddr,
  input  logic [bsmms_pkg::VAL_W-1:0]       wdata,
  input  logic [$clog2(DEPTH)-1:0]          raddr,
  output logic [bsmms_pkg::VAL_W-1:0]       rdata
);
  import bsmms_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/bsmms_gap_unit.sv */
// shared difference unit: registered absolute difference of two signed values
// depends on bsmms_pkg
`timescale 1ns / 1ps
module bsmms_gap_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic signed [bsmms_pkg::VAL_W-1:0] a,
  input  logic signed [bsmms_pkg::VAL_W-1:0] b,
  output logic                              vld,
  output logic [bsmms_pkg::VAL_W-1:0]       absd
);
  import bsmms_pkg::*;

  logic signed [VAL_W:0] diff;
  logic        [VAL_W:0] mag;

  always_comb begin
    diff = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    mag  = diff[VAL_W] ? (~diff + 1'b1) : diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= en;
    end
    absd <= mag[VAL_W-1:0];
  end

endmodule

/* hw/rtl/bounded_set_min_max_span.sv */
// Bounded set that reports the smallest and largest gap between held values.
// Each input beat offers one 64-bit signed value; a value is stored when the
// set is below capacity and the value fits in 32 signed bits. A stored value
// is compared against every held value through one memory read port and one
// shared difference unit, one held value per cycle; the scan then drains, the
// extremes and count are updated and the result is loaded. A first value skips
// the scan, a refused one skips scan and update, and loading the result waits
// until the output register is free. One beat is in work at a time; a finished
// result waits in the output register while the next beat is accepted.
// Capacity lives at APB address 0 and resets to 0.
// depends on bsmms_pkg, bsmms_mem, bsmms_gap_unit and the macros header
`timescale 1ns / 1ps
`include "bounded_set_min_max_span_macros.svh"
module bounded_set_min_max_span #(
  parameter int MAX_VALUES = bsmms_pkg::MAX_VALUES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bsmms_pkg::PADDR_W-1:0]        paddr,
  input  logic [bsmms_pkg::PDATA_W-1:0]        pwdata,
  output logic [bsmms_pkg::PDATA_W-1:0]        prdata,
  output logic                                 pready,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [bsmms_pkg::IN_W-1:0]           s_tdata,   // [63:0] value
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [6:0] count, [38:7] shortest_span, [70:39] longest_span, [71] zero pad
  output logic [bsmms_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [bsmms_pkg::OUT_USER_W-1:0]     m_tuser    // [1:0] status, [2] spans_valid
);
  import bsmms_pkg::*;

  localparam int AW = $clog2(MAX_VALUES);
  localparam int CW = $clog2(MAX_VALUES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t             state;
  status_t            status_r;
  logic [CNT_W-1:0]   capacity;
  logic [CW-1:0]      count;
  logic [VAL_W-1:0]   gap;
  logic signed [VAL_W-1:0] value;
  logic signed [VAL_W-1:0] least;
  logic signed [VAL_W-1:0] greatest;
  logic [AW-1:0]      idx;
  logic               rd_vld;

  logic               cfg_wr;
  logic               in_beat;
  logic               is_full;
  logic               in_range;
  logic               rd_en;
  logic               mem_we;
  logic               out_free;
  logic               out_load;
  logic [VAL_W-1:0]   rd_data;
  logic               gu_vld;
  logic [VAL_W-1:0]   gu_absd;
  logic [VAL_W-1:0]   span_long;
  logic               spans_ok;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == CAPACITY_ADDR);
  assign prdata = (paddr == CAPACITY_ADDR) ? {{(PDATA_W-CNT_W){1'b0}}, capacity} : '0;

  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign is_full  = (int'(count) >= int'(capacity)) || (int'(count) >= MAX_VALUES);
  assign in_range = (&s_tdata[IN_W-1:VAL_W-1]) || !(|s_tdata[IN_W-1:VAL_W-1]);
  assign rd_en    = (state == S_SCAN);
  assign mem_we   = (state == S_UPDATE) && (status_r == ST_STORED);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == S_FINISH) && out_free;
  assign span_long = greatest - least;
  assign spans_ok  = (count >= CW'(2));

  bsmms_mem #(
    .DEPTH (MAX_VALUES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(count)),
    .wdata (value),
    .raddr (idx),
    .rdata (rd_data)
  );

  bsmms_gap_unit u_gap (
    .clk  (clk),
    .rst  (rst),
    .en   (rd_vld),
    .a    (value),
    .b    (rd_data),
    .vld  (gu_vld),
    .absd (gu_absd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      status_r <= ST_STORED;
      capacity <= '0;
      count    <= '0;
      gap      <= GAP_INIT;
      least    <= '0;
      greatest <= '0;
      idx      <= '0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        capacity <= pwdata[CNT_W-1:0];
      end
      rd_vld <= rd_en;
      if (gu_vld && (gu_absd < gap)) begin
        gap <= gu_absd;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          if (in_beat) begin
            value <= s_tdata[VAL_W-1:0];
            priority if (is_full) begin
              status_r <= ST_FULL;
              state    <= S_FINISH;
            end else if (!in_range) begin
              status_r <= ST_RANGE;
              state    <= S_FINISH;
            end else begin
              status_r <= ST_STORED;
              state    <= (count == '0) ? S_UPDATE : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          if (int'(idx) + 1 >= int'(count)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_vld && !gu_vld) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (status_r == ST_STORED) begin
            count <= count + 1'b1;
            if (count == '0) begin
              least    <= value;
              greatest <= value;
            end else begin
              if (value < least) begin
                least <= value;
              end
              if (value > greatest) begin
                greatest <= value;
              end
            end
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            m_tdata  <= {1'b0,
                         spans_ok ? span_long : {VAL_W{1'b0}},
                         spans_ok ? gap : {VAL_W{1'b0}},
                         CNT_W'(count)};
            m_tuser  <= {spans_ok, status_r};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BSMMS_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, int'(count) <= MAX_VALUES)
  `BSMMS_ASSERT_IMP(a_read_in_set, clk, rst, rd_en, int'(idx) < int'(count))
  `BSMMS_ASSERT_NXT(a_store_grows, clk, rst, mem_we, count == $past(count) + 1'b1)
  `BSMMS_ASSERT_IMP(a_no_scan_busy, clk, rst, gu_vld, state == S_SCAN || state == S_DRAIN)

endmodule

/* bench/bounded_set_min_max_span_tb.sv */
`timescale 1ns / 1ps
// testbench for bounded_set_min_max_span: directed and random value beats with a
// self-contained prediction of count, spans and status; capacity set over apb
// depends on bsmms_pkg and the bounded_set_min_max_span top level
module bounded_set_min_max_span_tb;
  import bsmms_pkg::*;

  localparam int SET_DEPTH = MAX_VALUES_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = SET_DEPTH + 16;

  typedef struct packed {
    status_t     status;
    logic [6:0]  count;
    logic [31:0] shortest;
    logic [31:0] longest;
    logic        valid;
  } span_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;   // [6:0] count, [38:7] shortest, [70:39] longest, [71] pad
  logic [OUT_USER_W-1:0] m_tuser;   // [1:0] status, [2] spans_valid

  // predicted set contents
  logic [31:0]  held_vals [SET_DEPTH];
  int           held_cnt = 0;
  longint       min_gap = 64'd4294967295;
  longint       low_val = 0;
  longint       high_val = 0;
  logic [6:0]   cap_reg = '0;

  span_result_t expected_spans [$];
  int unsigned  fails = 0;
  int unsigned  cycles = 0;
  int unsigned  burst_left = 0;
  int unsigned  beats_sent = 0;
  int unsigned  stored_cnt = 0;
  int unsigned  full_cnt = 0;
  int unsigned  range_cnt = 0;
  int unsigned  cap_writes = 0;

  bounded_set_min_max_span #(.MAX_VALUES(SET_DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic span_result_t predict_add(input logic [63:0] raw);
    span_result_t r;
    longint v;
    longint d;
    r = '0;
    if (held_cnt >= cap_reg || held_cnt >= SET_DEPTH) begin
      r.status = ST_FULL;
      full_cnt++;
    end else if (!(raw[63:31] == '0 || raw[63:31] == '1)) begin
      r.status = ST_RANGE;
      range_cnt++;
    end else begin
      v = longint'($signed(raw[31:0]));
      for (int i = 0; i < held_cnt; i++) begin
        d = v - longint'($signed(held_vals[i]));
        if (d < 0) d = -d;
        if (d < min_gap) min_gap = d;
      end
      if (held_cnt == 0) begin
        low_val = v;
        high_val = v;
      end else begin
        if (v < low_val) low_val = v;
        if (v > high_val) high_val = v;
      end
      held_vals[held_cnt] = raw[31:0];
      held_cnt++;
      r.status = ST_STORED;
      stored_cnt++;
    end
    r.count = 7'(held_cnt);
    if (held_cnt >= 2) begin
      r.shortest = min_gap[31:0];
      r.longest = 32'(high_val - low_val);
      r.valid = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [63:0] pick_value();
    int unsigned kind;
    longint base;
    longint off;
    kind = $urandom_range(0, 99);
    if (kind < 15) return {$urandom, $urandom};
    if (kind < 25) begin
      base = $urandom_range(0, 1) ? 64'sh7FFF_FFFF : -64'sh8000_0000;
      off = longint'($urandom_range(0, 3));
      return $urandom_range(0, 1) ? base + off : base - off;
    end
    if (kind < 60 && held_cnt > 0) begin
      base = longint'($signed(held_vals[$urandom_range(0, held_cnt - 1)]));
      if (kind < 30 && held_cnt > 48) return base;
      off = longint'($urandom_range(1, 1 << $urandom_range(0, 20)));
      return $urandom_range(0, 1) ? base + off : base - off;
    end
    return longint'($signed($urandom));
  endfunction

  task automatic send_value(input logic [63:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) begin
          s_tdata <= {$urandom, $urandom};
          @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_spans.insert(expected_spans.size(), predict_add(v));
    beats_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_spans.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_capacity(input logic [6:0] cap);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= PDATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cap_reg = cap;
    cap_writes++;
    // read back
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== PDATA_W'(cap)) begin
      $error("capacity readback: expected %0d, got %0d", cap, prdata);
      fails++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_empty_set();
    send_value(64'd0);
    send_value(64'h7FFF_FFFF_FFFF_FFFF);
    send_value(64'h8000_0000_0000_0000);
  endtask

  task automatic test_out_of_range();
    set_capacity(7'd4);
    send_value(64'h0000_0000_8000_0000);
    send_value(64'hFFFF_FFFF_7FFF_FFFF);
    send_value(64'h7FFF_FFFF_FFFF_FFFF);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'h0000_0001_0000_0000);
    send_value(64'hFFFF_FFFF_0000_0000);
  endtask

  task automatic test_first_values();
    send_value(64'd0);
    send_value(64'h0000_0000_7FFF_FFFF);
    send_value(64'hFFFF_FFFF_8000_0000);
  endtask

  task automatic test_full_refusal();
    send_value(64'd1000);
    send_value(64'd5);
    send_value(64'h0000_0100_0000_0000);
    set_capacity(7'd1);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    set_capacity(7'd127);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    send_value(64'd1);
  endtask

  task automatic test_random_fill();
    logic [6:0] caps [12] = '{7'd8, 7'd3, 7'd16, 7'd0, 7'd24, 7'd32,
                              7'd40, 7'd52, 7'd60, 7'd64, 7'd1, 7'd127};
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      repeat (160) send_value(pick_value());
    end
  endtask

  // receiver stalls
  initial begin
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(30, 200)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    span_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_spans.size() == 0) begin
        $error("result beat with no value pending");
        fails++;
      end else begin
        want = expected_spans.pop_front();
        if (m_tuser[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser[1:0]);
          fails++;
        end
        if (m_tdata[6:0] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, m_tdata[6:0]);
          fails++;
        end
        if (m_tdata[38:7] !== want.shortest) begin
          $error("shortest_span: expected %0d, got %0d", want.shortest, m_tdata[38:7]);
          fails++;
        end
        if (m_tdata[70:39] !== want.longest) begin
          $error("longest_span: expected %0d, got %0d", want.longest, m_tdata[70:39]);
          fails++;
        end
        if (m_tuser[2] !== want.valid) begin
          $error("spans_valid: expected %0d, got %0d", want.valid, m_tuser[2]);
          fails++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_set();
    test_out_of_range();
    test_first_values();
    test_full_refusal();
    test_random_fill();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_spans.size() != 0) begin
      $error("%0d results never arrived", expected_spans.size());
      fails++;
    end
    $display("%0d value beats offered: %0d stored, %0d refused as full, %0d out of range",
             beats_sent, stored_cnt, full_cnt, range_cnt);
    $display("%0d capacity writes, set ended with %0d values", cap_writes, held_cnt);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bsmms_pkg.sv
hw/rtl/bsmms_mem.sv
hw/rtl/bsmms_gap_unit.sv
hw/rtl/bounded_set_min_max_span.sv
bench/bounded_set_min_max_span_tb.sv
